// ===== hw/rtl/graph_dfs_path_finder_defines.svh =====
// assertion macros used by the graph search controller rtl
`ifndef GRAPH_DFS_PATH_FINDER_DEFINES_SVH
`define GRAPH_DFS_PATH_FINDER_DEFINES_SVH

// clocked check, masked while reset is asserted
`define GDFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define GDFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gdfs_pkg.sv =====
// types and constants of the graph path search block
`default_nettype none
package gdfs_pkg;

    localparam int VTX_W = 6;
    localparam int PAR_W = 7;
    localparam logic [PAR_W-1:0] NO_PARENT = 7'd127;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
    localparam logic [1:0] OP_FIND_PATH  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_UNREACH  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [1:0] DEG_SEL_A   = 2'd0;
    localparam logic [1:0] DEG_SEL_B   = 2'd1;
    localparam logic [1:0] DEG_SEL_STK = 2'd2;

    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_CNT  = 2'd1;
    localparam logic [1:0] EMIT_PATH = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [VTX_W-1:0] path_vertex;
        logic             has_vertex;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       cnt_inc;
        logic       deg_rd;
        logic [1:0] deg_sel;
        logic       deg_x_cap;
        logic       deg_y_cap;
        logic       idx_clr;
        logic       idx_inc;
        logic       nbr_rd;
        logic       nbr_base_cur;
        logic       nbr_wr_a;
        logic       nbr_wr_b;
        logic       srch_init;
        logic       pop;
        logic       visit;
        logic       push;
        logic       path_init;
        logic       par_rd;
        logic       path_adv;
        logic       emit;
        logic [2:0] emit_status;
        logic [1:0] emit_src;
        logic       emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [1:0] op;
        logic       full;
        logic       a_bad;
        logic       b_bad;
        logic       a_eq_b;
        logic       deg_x_full;
        logic       deg_y_full;
        logic       idx_lt_deg;
        logic       nbr_eq_b;
        logic       sp_zero;
        logic       sp_full;
        logic       cur_skip;
        logic       cur_is_goal;
        logic       nb_skip;
        logic       path_last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gdfs_dpath.sv =====
// datapath: graph stores, search stack, path walk and output register
`default_nettype none
module gdfs_dpath
    import gdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 8,
    parameter int STACK_DEPTH  = 1024
) (
    input  wire        clk,
    input  wire        rst_n,
    input  in_item_t   in_data,
    input  ctl_cmd_t   cmd,
    output dp_status_t sts,
    input  wire        out_ready,
    output logic       out_valid,
    output out_item_t  out_data
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int NW  = $clog2(MAX_VERTICES);

    logic [DW-1:0]    deg_mem [MAX_VERTICES];
    logic [VTX_W-1:0] nbr_mem [MAX_VERTICES * MAX_DEGREE];
    logic [PAR_W-1:0] par_mem [MAX_VERTICES];
    logic [VTX_W-1:0] stk_mem [STACK_DEPTH];

    logic [1:0]        op_reg;
    logic [VTX_W-1:0]  a_reg;
    logic [VTX_W-1:0]  b_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     deg_x_reg;
    logic [DW-1:0]     deg_y_reg;
    logic [DW-1:0]     idx_reg;
    logic [VTX_W-1:0]  cur_reg;
    logic [SPW-1:0]    sp_reg;
    logic [VTX_W-1:0]  v_reg;
    logic [NW-1:0]     n_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [DW-1:0]     deg_rd_reg;
    logic              deg_rv_reg;
    logic [VTX_W-1:0]  nbr_rd_reg;
    logic [VTX_W-1:0]  stk_rd_reg;
    logic [PAR_W-1:0]  par_rd_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [DW-1:0]    deg_eff;
    logic [VTX_W-1:0] deg_addr;
    logic [NAW-1:0]   nbr_rd_addr;
    logic [VTX_W-1:0] nbr_base;
    logic             out_free;
    logic [SPW-1:0]   sp_dec;

    assign deg_eff  = deg_rv_reg ? deg_rd_reg : '0;
    assign out_free = !out_valid_reg || out_ready;
    assign sp_dec   = sp_reg - 1'b1;
    assign nbr_base = cmd.nbr_base_cur ? cur_reg : a_reg;
    assign nbr_rd_addr = NAW'(nbr_base) * NAW'(MAX_DEGREE) + NAW'(idx_reg);

    always_comb
    begin
        case (cmd.deg_sel)
            DEG_SEL_A:   deg_addr = a_reg;
            DEG_SEL_B:   deg_addr = b_reg;
            DEG_SEL_STK: deg_addr = stk_rd_reg;
            default:     deg_addr = a_reg;
        endcase
    end

    // degree store, entries count as zero until first written
    always_ff @(posedge clk)
    begin
        if (cmd.deg_rd)
        begin
            deg_rd_reg <= deg_mem[deg_addr[VAW-1:0]];
        end
        if (cmd.nbr_wr_a)
        begin
            deg_mem[a_reg[VAW-1:0]] <= deg_x_reg + 1'b1;
        end
        else if (cmd.nbr_wr_b)
        begin
            deg_mem[b_reg[VAW-1:0]] <= deg_y_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.nbr_rd)
        begin
            nbr_rd_reg <= nbr_mem[nbr_rd_addr];
        end
        if (cmd.nbr_wr_a)
        begin
            nbr_mem[NAW'(a_reg) * NAW'(MAX_DEGREE) + NAW'(deg_x_reg)] <= b_reg;
        end
        else if (cmd.nbr_wr_b)
        begin
            nbr_mem[NAW'(b_reg) * NAW'(MAX_DEGREE) + NAW'(deg_y_reg)] <= a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.par_rd)
        begin
            par_rd_reg <= par_mem[v_reg[VAW-1:0]];
        end
        if (cmd.srch_init)
        begin
            par_mem[a_reg[VAW-1:0]] <= NO_PARENT;
        end
        else if (cmd.push)
        begin
            par_mem[nbr_rd_reg[VAW-1:0]] <= {1'b0, cur_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            stk_rd_reg <= stk_mem[sp_dec[SAW-1:0]];
        end
        if (cmd.srch_init)
        begin
            stk_mem[0] <= a_reg;
        end
        else if (cmd.push)
        begin
            stk_mem[sp_reg[SAW-1:0]] <= nbr_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= in_data.op;
            a_reg  <= in_data.vertex_a;
            b_reg  <= in_data.vertex_b;
        end
        if (cmd.deg_x_cap)
        begin
            deg_x_reg <= deg_eff;
        end
        if (cmd.deg_y_cap)
        begin
            deg_y_reg <= deg_eff;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.visit)
        begin
            cur_reg <= stk_rd_reg;
        end
        if (cmd.path_init)
        begin
            v_reg <= b_reg;
            n_reg <= '0;
        end
        else if (cmd.path_adv)
        begin
            v_reg <= par_rd_reg[VTX_W-1:0];
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_data_reg.status      <= cmd.emit_status;
            out_data_reg.has_vertex  <= (cmd.emit_src != EMIT_NONE);
            out_data_reg.last        <= cmd.emit_last;
            case (cmd.emit_src)
                EMIT_CNT:  out_data_reg.path_vertex <= VTX_W'(cnt_reg);
                EMIT_PATH: out_data_reg.path_vertex <= v_reg;
                default:   out_data_reg.path_vertex <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sp_reg        <= '0;
            visited_reg   <= '0;
            deg_vld_reg   <= '0;
            deg_rv_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.deg_rd)
            begin
                deg_rv_reg <= deg_vld_reg[deg_addr[VAW-1:0]];
            end
            if (cmd.nbr_wr_a)
            begin
                deg_vld_reg[a_reg[VAW-1:0]] <= 1'b1;
            end
            else if (cmd.nbr_wr_b)
            begin
                deg_vld_reg[b_reg[VAW-1:0]] <= 1'b1;
            end
            if (cmd.srch_init)
            begin
                sp_reg      <= SPW'(1);
                visited_reg <= '0;
            end
            else
            begin
                if (cmd.pop)
                begin
                    sp_reg <= sp_dec;
                end
                else if (cmd.push)
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
                if (cmd.visit)
                begin
                    visited_reg[stk_rd_reg[VAW-1:0]] <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.out_free    = out_free;
        sts.op          = op_reg;
        sts.full        = (cnt_reg >= CW'(MAX_VERTICES));
        sts.a_bad       = ({1'b0, a_reg} >= 7'(cnt_reg));
        sts.b_bad       = ({1'b0, b_reg} >= 7'(cnt_reg));
        sts.a_eq_b      = (a_reg == b_reg);
        sts.deg_x_full  = (deg_x_reg >= DW'(MAX_DEGREE));
        sts.deg_y_full  = (deg_y_reg >= DW'(MAX_DEGREE));
        sts.idx_lt_deg  = (idx_reg < deg_x_reg);
        sts.nbr_eq_b    = (nbr_rd_reg == b_reg);
        sts.sp_zero     = (sp_reg == '0);
        sts.sp_full     = (sp_reg >= SPW'(STACK_DEPTH));
        sts.cur_skip    = ({1'b0, stk_rd_reg} >= 7'(MAX_VERTICES))
                          || visited_reg[stk_rd_reg[VAW-1:0]];
        sts.cur_is_goal = (stk_rd_reg == b_reg);
        sts.nb_skip     = ({1'b0, nbr_rd_reg} >= 7'(MAX_VERTICES))
                          || visited_reg[nbr_rd_reg[VAW-1:0]];
        sts.path_last   = !((par_rd_reg != {1'b0, a_reg})
                          && (par_rd_reg < PAR_W'(MAX_VERTICES))
                          && (({1'b0, n_reg} + 1'b1) < (NW + 1)'(MAX_VERTICES - 1)));
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/gdfs_ctrl.sv =====
// controller: sequences vertex, edge and search operations
`default_nettype none
`include "graph_dfs_path_finder_defines.svh"
module gdfs_ctrl
    import gdfs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output ctl_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_E_RDB  = 5'd2;
    localparam logic [4:0] S_E_CAPB = 5'd3;
    localparam logic [4:0] S_E_SCAN = 5'd4;
    localparam logic [4:0] S_E_CMP  = 5'd5;
    localparam logic [4:0] S_E_CHK  = 5'd6;
    localparam logic [4:0] S_E_WA   = 5'd7;
    localparam logic [4:0] S_E_WB   = 5'd8;
    localparam logic [4:0] S_E_OK   = 5'd9;
    localparam logic [4:0] S_INIT   = 5'd10;
    localparam logic [4:0] S_POP    = 5'd11;
    localparam logic [4:0] S_POPW   = 5'd12;
    localparam logic [4:0] S_DEG    = 5'd13;
    localparam logic [4:0] S_NB     = 5'd14;
    localparam logic [4:0] S_NBW    = 5'd15;
    localparam logic [4:0] S_GOAL   = 5'd16;
    localparam logic [4:0] S_P_RD   = 5'd17;
    localparam logic [4:0] S_P_CHK  = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.load_in = in_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.op == OP_ADD_EDGE && !sts.a_bad && !sts.b_bad)
                begin
                    cmd.deg_rd  = 1'b1;
                    cmd.deg_sel = DEG_SEL_A;
                    state_next  = S_E_RDB;
                end
                else if (sts.op == OP_FIND_PATH && !sts.a_bad && !sts.b_bad)
                begin
                    state_next = S_INIT;
                end
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (sts.op == OP_ADD_VERTEX)
                    begin
                        cmd.emit_status = sts.full ? ST_FULL : ST_OK;
                        cmd.emit_src    = sts.full ? EMIT_NONE : EMIT_CNT;
                        cmd.cnt_inc     = !sts.full;
                    end
                    else
                    begin
                        cmd.emit_status = ST_BAD;
                    end
                    state_next = S_IDLE;
                end
            end
            S_E_RDB:
            begin
                cmd.deg_x_cap = 1'b1;
                cmd.deg_rd    = 1'b1;
                cmd.deg_sel   = DEG_SEL_B;
                state_next    = S_E_CAPB;
            end
            S_E_CAPB:
            begin
                cmd.deg_y_cap = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_E_SCAN;
            end
            S_E_SCAN:
            begin
                if (sts.idx_lt_deg)
                begin
                    cmd.nbr_rd = 1'b1;
                    state_next = S_E_CMP;
                end
                else
                begin
                    state_next = S_E_CHK;
                end
            end
            S_E_CMP:
            begin
                if (!sts.nbr_eq_b)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_E_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DUP;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_E_CHK:
            begin
                if (!sts.deg_x_full && !sts.deg_y_full)
                begin
                    state_next = S_E_WA;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_BAD;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_E_WA:
            begin
                cmd.nbr_wr_a = 1'b1;
                state_next   = sts.a_eq_b ? S_E_OK : S_E_WB;
            end
            S_E_WB:
            begin
                cmd.nbr_wr_b = 1'b1;
                state_next   = S_E_OK;
            end
            S_E_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_INIT:
            begin
                cmd.srch_init = 1'b1;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if (!sts.sp_zero)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPW;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_UNREACH;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_POPW:
            begin
                if (sts.cur_skip)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.visit = 1'b1;
                    if (sts.cur_is_goal)
                    begin
                        state_next = S_GOAL;
                    end
                    else
                    begin
                        cmd.deg_rd  = 1'b1;
                        cmd.deg_sel = DEG_SEL_STK;
                        state_next  = S_DEG;
                    end
                end
            end
            S_DEG:
            begin
                cmd.deg_x_cap = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_NB;
            end
            S_NB:
            begin
                if (sts.idx_lt_deg)
                begin
                    cmd.nbr_rd       = 1'b1;
                    cmd.nbr_base_cur = 1'b1;
                    state_next       = S_NBW;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_NBW:
            begin
                if (sts.nb_skip)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_NB;
                end
                else if (!sts.sp_full)
                begin
                    cmd.push    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_NB;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OVERFLOW;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_GOAL:
            begin
                if (!sts.a_eq_b)
                begin
                    cmd.path_init = 1'b1;
                    state_next    = S_P_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_P_RD:
            begin
                cmd.par_rd = 1'b1;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_src    = EMIT_PATH;
                    cmd.emit_last   = sts.path_last;
                    cmd.path_adv    = 1'b1;
                    state_next      = sts.path_last ? S_IDLE : S_P_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `GDFS_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "emit while output busy")
    `GDFS_ASSERT(a_push_room, cmd.push |-> !sts.sp_full, "push onto full stack")
    `GDFS_ASSERT(a_pop_data, cmd.pop |-> !sts.sp_zero, "pop from empty stack")
    `GDFS_ASSERT(a_fire_decode, in_fire |=> state_reg == S_DECODE, "transfer not decoded")
    `GDFS_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !cmd.emit || state_reg != S_IDLE,
        "emit from idle in reset")

endmodule
`default_nettype wire

// ===== hw/rtl/graph_dfs_path_finder.sv =====
// top level of the graph store with depth-first path search
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_item_t  (op, vertex_a, vertex_b)
//  out      out  out_valid/out_ready  out_item_t (status, path_vertex, has_vertex, last)
//
// add vertex answers from the decode step; add edge first scans each stored neighbor
// of vertex_a for a duplicate; a search pops vertices and inspects their neighbors
// through the single stack, neighbor and degree memory ports; the path walk
// reads the parent of each path vertex before giving that vertex out
// reset clears vertex count, degree valid bits and stack pointer; no clearing pass
// a stalled out channel holds the sequencer at its next result; in_ready is high
// only between operations, even while the last result still waits
`default_nettype none
module graph_dfs_path_finder
    import gdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 8,
    parameter int STACK_DEPTH  = 1024
) (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  wire       out_ready,
    output out_item_t out_data
);

    // command and status between sequencer and datapath
    ctl_cmd_t   cmd;
    dp_status_t sts;

    gdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, stack, path walk and output register
    gdfs_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
